/* src/ppp_pkg.sv */
// Shared constants, codes and types of the pixel preprocess block.
`timescale 1ns / 1ps

package ppp_pkg;

    // Widths
    localparam int COORD_BITS    = 12;
    localparam int FACTOR_BITS   = 4;
    localparam int PIX_BITS      = 16;
    localparam int LUMA_BITS     = 8;
    localparam int TCTL_BITS     = 10;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COORD_BITS;
    localparam int DIV_CNT_BITS  = $clog2(COORD_BITS);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_ROI_LEFT     = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_ROI_TOP      = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_ROI_COLS     = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] REG_ROI_ROWS     = CFG_IDX_BITS'(5);
    localparam logic [CFG_IDX_BITS-1:0] REG_DECIMATION   = CFG_IDX_BITS'(6);
    localparam logic [CFG_IDX_BITS-1:0] REG_THR_CTL      = CFG_IDX_BITS'(7);

    // Register reset values
    localparam logic [COORD_BITS-1:0]  RST_FRAME_WIDTH  = COORD_BITS'(320);
    localparam logic [COORD_BITS-1:0]  RST_FRAME_HEIGHT = COORD_BITS'(240);
    localparam logic [FACTOR_BITS-1:0] RST_DECIMATION   = FACTOR_BITS'(1);
    localparam logic [TCTL_BITS-1:0]   RST_THR_CTL      = TCTL_BITS'(128);

    // Threshold control fields
    localparam int TCTL_BIN_BIT = 8;
    localparam int TCTL_INV_BIT = 9;

    // Channel expansion and luma weights
    localparam int EXP5_MUL = 527;
    localparam int EXP5_ADD = 23;
    localparam int EXP6_MUL = 259;
    localparam int EXP6_ADD = 33;
    localparam int Y_WR     = 77;
    localparam int Y_WG     = 150;
    localparam int Y_WB     = 29;

    // Last step of the serial output-size divider
    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(COORD_BITS - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CLAMP  = 6'b000010,
        S_SIZE   = 6'b000100,
        S_DIV    = 6'b001000,
        S_EXPAND = 6'b010000,
        S_MIX    = 6'b100000
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // take the offered pixel and advance the counters
        logic geom_org;   // clamp the crop origin and the factor
        logic geom_size;  // clamp the crop size and load the divider
        logic div_step;   // one restoring division step
        logic expand;     // widen the channels to 8 bits
        logic mix;        // form luma and load the output register
    } t_ctl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic keep;       // offered pixel is kept
        logic out_free;   // output register can take a result this cycle
    } t_ctl_stat;

endpackage

/* src/ppp_pix_in_if.sv */
// Input pixel channel interface.
`timescale 1ns / 1ps

interface ppp_pix_in_if;
    logic                          valid;
    logic                          ready;
    logic [ppp_pkg::PIX_BITS-1:0]  pixel_rgb565;
    logic                          frame_start;

    modport source (output valid, output pixel_rgb565, output frame_start, input ready);
    modport sink   (input valid, input pixel_rgb565, input frame_start, output ready);
    modport mon    (input valid, input pixel_rgb565, input frame_start, input ready);
endinterface

/* src/ppp_pix_out_if.sv */
// Output pixel channel interface.
`timescale 1ns / 1ps

interface ppp_pix_out_if;
    logic                          valid;
    logic                          ready;
    logic [ppp_pkg::LUMA_BITS-1:0] pixel_out;
    logic                          line_end;
    logic                          frame_end;

    modport source (output valid, output pixel_out, output line_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel_out, input line_end, input frame_end,
                    output ready);
    modport mon    (input valid, input pixel_out, input line_end, input frame_end,
                    input ready);
endinterface

/* src/ppp_cfg_if.sv */
// Configuration write channel interface.
`timescale 1ns / 1ps

interface ppp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ppp_pkg::CFG_IDX_BITS-1:0]  index;
    logic [ppp_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
    modport mon    (input valid, input index, input data, input ready);
endinterface

/* src/ppp_ctrl.sv */
// Controller state machine that sequences geometry setup and pixel processing.
`timescale 1ns / 1ps

module ppp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_cfg_we,
    input  ppp_pkg::t_ctl_stat    i_stat,
    output logic                  o_in_ready,
    output ppp_pkg::t_ctl_cmd     o_cmd
);

    ppp_pkg::t_state                   r_state, n_state;
    logic                              r_dirty, n_dirty;
    logic [ppp_pkg::DIV_CNT_BITS-1:0]  r_div_cnt, n_div_cnt;

    // Any register write makes the derived geometry stale until it is recomputed.
    assign n_dirty    = i_cfg_we || (r_dirty && (r_state != ppp_pkg::S_IDLE));
    assign o_in_ready = (r_state == ppp_pkg::S_IDLE) && !r_dirty;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        case (r_state)
            ppp_pkg::S_IDLE: begin
                if (r_dirty) begin
                    n_state = ppp_pkg::S_CLAMP;
                end else if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.keep) begin
                        n_state = ppp_pkg::S_EXPAND;
                    end
                end
            end
            ppp_pkg::S_CLAMP: begin
                o_cmd.geom_org = 1'b1;
                n_state        = ppp_pkg::S_SIZE;
            end
            ppp_pkg::S_SIZE: begin
                o_cmd.geom_size = 1'b1;
                n_div_cnt       = '0;
                n_state         = ppp_pkg::S_DIV;
            end
            ppp_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == ppp_pkg::DIV_LAST) begin
                    n_state = ppp_pkg::S_IDLE;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            ppp_pkg::S_EXPAND: begin
                o_cmd.expand = 1'b1;
                n_state      = ppp_pkg::S_MIX;
            end
            ppp_pkg::S_MIX: begin
                if (i_stat.out_free) begin
                    o_cmd.mix = 1'b1;
                    n_state   = ppp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ppp_pkg::S_IDLE;
            r_dirty   <= 1'b1;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_dirty   <= n_dirty;
            r_div_cnt <= n_div_cnt;
        end
    end

endmodule

/* src/ppp_datapath.sv */
// Datapath: registers, crop geometry, position counters, luma arithmetic, output register.
`timescale 1ns / 1ps

module ppp_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ppp_pkg::t_ctl_cmd                   i_cmd,
    output ppp_pkg::t_ctl_stat                  o_stat,
    input  logic                                i_cfg_we,
    input  logic [ppp_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [ppp_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic [ppp_pkg::PIX_BITS-1:0]        i_pixel_rgb565,
    input  logic                                i_frame_start,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ppp_pkg::LUMA_BITS-1:0]       o_pixel_out,
    output logic                                o_line_end,
    output logic                                o_frame_end
);

    localparam int CB = ppp_pkg::COORD_BITS;
    localparam int FB = ppp_pkg::FACTOR_BITS;
    localparam int LB = ppp_pkg::LUMA_BITS;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [FB-1:0] phase_inc(input logic [FB-1:0] ph,
                                                input logic [FB-1:0] f);
        logic [FB:0] ph1;
        ph1       = {1'b0, ph} + 1'b1;
        phase_inc = (ph1 >= {1'b0, f}) ? '0 : ph1[FB-1:0];
    endfunction

    // Configuration registers
    logic [CB-1:0]                   r_frame_width, r_frame_height;
    logic [CB-1:0]                   r_roi_left, r_roi_top, r_roi_cols, r_roi_rows;
    logic [FB-1:0]                   r_decimation;
    logic [ppp_pkg::TCTL_BITS-1:0]   r_thr_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ppp_pkg::RST_FRAME_WIDTH;
            r_frame_height <= ppp_pkg::RST_FRAME_HEIGHT;
            r_roi_left     <= '0;
            r_roi_top      <= '0;
            r_roi_cols     <= '0;
            r_roi_rows     <= '0;
            r_decimation   <= ppp_pkg::RST_DECIMATION;
            r_thr_ctl      <= ppp_pkg::RST_THR_CTL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ppp_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                ppp_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                ppp_pkg::REG_ROI_LEFT:     r_roi_left     <= i_cfg_data;
                ppp_pkg::REG_ROI_TOP:      r_roi_top      <= i_cfg_data;
                ppp_pkg::REG_ROI_COLS:     r_roi_cols     <= i_cfg_data;
                ppp_pkg::REG_ROI_ROWS:     r_roi_rows     <= i_cfg_data;
                ppp_pkg::REG_DECIMATION:   r_decimation   <= i_cfg_data[FB-1:0];
                ppp_pkg::REG_THR_CTL:
                    r_thr_ctl <= i_cfg_data[ppp_pkg::TCTL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Crop geometry and output size; the quotient forms in r_nw / r_nh.
    logic [CB-1:0] r_rx, r_ry, r_rw, r_rh, r_nw, r_nh;
    logic [FB-1:0] r_fac, r_rem_w, r_rem_h;
    logic [CB-1:0] w_m1, h_m1, w_left, h_left, rw_c, rh_c;
    logic          no_crop;
    logic [FB:0]   sh_w, sh_h;
    logic          qb_w, qb_h;

    assign w_m1    = r_frame_width - 1'b1;
    assign h_m1    = r_frame_height - 1'b1;
    assign w_left  = r_frame_width - r_rx;
    assign h_left  = r_frame_height - r_ry;
    assign rw_c    = (r_roi_cols < w_left) ? r_roi_cols : w_left;
    assign rh_c    = (r_roi_rows < h_left) ? r_roi_rows : h_left;
    assign no_crop = (rw_c == '0) || (rh_c == '0);

    assign sh_w = {r_rem_w, r_nw[CB-1]};
    assign sh_h = {r_rem_h, r_nh[CB-1]};
    assign qb_w = (sh_w >= {1'b0, r_fac});
    assign qb_h = (sh_h >= {1'b0, r_fac});

    always_ff @(posedge i_clk) begin
        if (i_cmd.geom_org) begin
            r_rx  <= (r_roi_left < w_m1) ? r_roi_left : w_m1;
            r_ry  <= (r_roi_top < h_m1) ? r_roi_top : h_m1;
            r_fac <= (r_decimation > FB'(1)) ? r_decimation : FB'(1);
        end else if (i_cmd.geom_size) begin
            r_rx    <= no_crop ? '0 : r_rx;
            r_ry    <= no_crop ? '0 : r_ry;
            r_rw    <= no_crop ? r_frame_width : rw_c;
            r_rh    <= no_crop ? r_frame_height : rh_c;
            r_nw    <= no_crop ? r_frame_width : rw_c;
            r_nh    <= no_crop ? r_frame_height : rh_c;
            r_rem_w <= '0;
            r_rem_h <= '0;
        end else if (i_cmd.div_step) begin
            r_rem_w <= qb_w ? FB'(sh_w - {1'b0, r_fac}) : sh_w[FB-1:0];
            r_rem_h <= qb_h ? FB'(sh_h - {1'b0, r_fac}) : sh_h[FB-1:0];
            r_nw    <= {r_nw[CB-2:0], qb_w};
            r_nh    <= {r_nh[CB-2:0], qb_h};
        end
    end

    // Position counters
    logic [CB-1:0] r_in_col, r_in_row, r_out_col, r_out_row;
    logic [FB-1:0] r_col_ph, r_row_ph;
    logic [CB-1:0] n_in_col, n_in_row, n_out_col, n_out_row;
    logic [FB-1:0] n_col_ph, n_row_ph;
    logic [CB-1:0] e_in_col, e_in_row, e_out_col, e_out_row;
    logic [FB-1:0] e_col_ph, e_row_ph;
    logic          empty, ccol, crow, keep_c, col_last, row_last, col_wrap, row_wrap;

    // A frame start clears the counters before the pixel is looked at.
    assign e_in_col  = i_frame_start ? '0 : r_in_col;
    assign e_in_row  = i_frame_start ? '0 : r_in_row;
    assign e_out_col = i_frame_start ? '0 : r_out_col;
    assign e_out_row = i_frame_start ? '0 : r_out_row;
    assign e_col_ph  = i_frame_start ? '0 : r_col_ph;
    assign e_row_ph  = i_frame_start ? '0 : r_row_ph;

    assign empty    = (r_frame_width == '0) || (r_frame_height == '0);
    assign ccol     = (e_in_col >= r_rx) && ((e_in_col - r_rx) < r_rw);
    assign crow     = (e_in_row >= r_ry) && ((e_in_row - r_ry) < r_rh);
    assign keep_c   = !empty && ccol && crow && (e_col_ph == '0) && (e_row_ph == '0)
                      && (e_out_col < r_nw) && (e_out_row < r_nh);
    assign col_last = (({1'b0, e_out_col} + 1'b1) == {1'b0, r_nw});
    assign row_last = (({1'b0, e_out_row} + 1'b1) == {1'b0, r_nh});
    assign col_wrap = (({1'b0, e_in_col} + 1'b1) >= {1'b0, r_frame_width});
    assign row_wrap = (({1'b0, e_in_row} + 1'b1) >= {1'b0, r_frame_height});

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_col_ph  = r_col_ph;
        n_row_ph  = r_row_ph;
        if (i_cmd.accept) begin
            if (empty) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_col_ph  = '0;
                n_row_ph  = '0;
            end else begin
                n_in_row  = e_in_row;
                n_out_col = e_out_col;
                n_out_row = e_out_row;
                n_col_ph  = e_col_ph;
                n_row_ph  = e_row_ph;
                if (ccol) begin
                    if (e_col_ph == '0) begin
                        n_out_col = sat_inc(e_out_col);
                    end
                    n_col_ph = phase_inc(e_col_ph, r_fac);
                end
                if (col_wrap) begin
                    n_in_col  = '0;
                    n_col_ph  = '0;
                    n_out_col = '0;
                    if (crow) begin
                        if (e_row_ph == '0) begin
                            n_out_row = sat_inc(e_out_row);
                        end
                        n_row_ph = phase_inc(e_row_ph, r_fac);
                    end
                    if (row_wrap) begin
                        n_in_row  = '0;
                        n_out_row = '0;
                        n_row_ph  = '0;
                    end else begin
                        n_in_row = e_in_row + 1'b1;
                    end
                end else begin
                    n_in_col = e_in_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_col_ph  <= '0;
            r_row_ph  <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_col_ph  <= n_col_ph;
            r_row_ph  <= n_row_ph;
        end
    end

    // Pixel capture, channel expansion, luma
    logic [ppp_pkg::PIX_BITS-1:0] r_pix;
    logic                         r_le, r_fe;
    logic [LB-1:0]                r_r8, r_g8, r_b8;
    logic [15:0]                  exp_r, exp_g, exp_b, mix_sum;
    logic [LB-1:0]                luma, res;
    logic                         pass;

    assign exp_r = 16'(r_pix[15:11]) * 16'(ppp_pkg::EXP5_MUL) + 16'(ppp_pkg::EXP5_ADD);
    assign exp_g = 16'(r_pix[10:5]) * 16'(ppp_pkg::EXP6_MUL) + 16'(ppp_pkg::EXP6_ADD);
    assign exp_b = 16'(r_pix[4:0]) * 16'(ppp_pkg::EXP5_MUL) + 16'(ppp_pkg::EXP5_ADD);

    assign mix_sum = 16'(r_r8) * 16'(ppp_pkg::Y_WR) + 16'(r_g8) * 16'(ppp_pkg::Y_WG)
                   + 16'(r_b8) * 16'(ppp_pkg::Y_WB);
    assign luma    = mix_sum[15:8];
    assign pass    = (luma >= r_thr_ctl[LB-1:0]) ^ r_thr_ctl[ppp_pkg::TCTL_INV_BIT];
    assign res     = r_thr_ctl[ppp_pkg::TCTL_BIN_BIT] ? (pass ? '1 : '0) : luma;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_pixel_rgb565;
            r_le  <= col_last;
            r_fe  <= col_last && row_last;
        end
        if (i_cmd.expand) begin
            r_r8 <= exp_r[13:6];
            r_g8 <= exp_g[13:6];
            r_b8 <= exp_b[13:6];
        end
    end

    // Output register
    logic r_out_valid;
    logic [LB-1:0] r_out_pix;
    logic r_out_le, r_out_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.mix) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_out_pix <= res;
            r_out_le  <= r_le;
            r_out_fe  <= r_fe;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_out     = r_out_pix;
    assign o_line_end      = r_out_le;
    assign o_frame_end     = r_out_fe;
    assign o_stat.keep     = keep_c;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

/* src/pixel_preprocess_pipeline_unit.sv */
// Top level of the RGB565 grayscale, crop, decimate and threshold pixel preprocessor.
`timescale 1ns / 1ps

// Raster-order RGB565 pixels arrive on i_pix; each one is either dropped or
// turned into one 8-bit luma (or binarized 0/255) result on o_pix, marked
// with line and frame ends of the cropped and decimated output frame.
// A dropped pixel is only transferred and counted; a kept pixel passes
// through transfer and position update, channel expansion, and luma mix and
// threshold, which waits while the output register holds a result that
// o_pix.ready has not taken. The next pixel is taken while a finished
// result still waits in the output register. After reset and after every
// configuration write the block derives the clamped crop window and the
// output frame size with a one-bit-per-cycle divider; i_pix.ready stays low
// meanwhile. Configuration transfers are always taken and must arrive only
// while no pixel is in flight.

module pixel_preprocess_pipeline_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ppp_pix_in_if.sink   i_pix,
    ppp_pix_out_if.source o_pix,
    ppp_cfg_if.sink      i_cfg
);

    ppp_pkg::t_ctl_cmd  cmd;
    ppp_pkg::t_ctl_stat stat;
    logic               cfg_we;

    // Register writes are taken at once.
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    // The controller sequences geometry setup and the stages of a kept pixel.
    ppp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .i_cfg_we   (cfg_we),
        .i_stat     (stat),
        .o_in_ready (i_pix.ready),
        .o_cmd      (cmd)
    );

    // The datapath holds the registers, counters, arithmetic and output register.
    ppp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_pixel_rgb565 (i_pix.pixel_rgb565),
        .i_frame_start  (i_pix.frame_start),
        .o_out_valid    (o_pix.valid),
        .i_out_ready    (o_pix.ready),
        .o_pixel_out    (o_pix.pixel_out),
        .o_line_end     (o_pix.line_end),
        .o_frame_end    (o_pix.frame_end)
    );

endmodule

/* src/ppp_checker.sv */
// Port-level assertions for the pixel preprocessor and the bind that attaches them.
`timescale 1ns / 1ps

module ppp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_pix_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ppp_pkg::LUMA_BITS-1:0] i_pixel_out,
    input logic                          i_line_end,
    input logic                          i_frame_end,
    input logic                          i_cfg_valid,
    input logic                          i_cfg_ready
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped before transfer");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_pixel_out) && $stable(i_line_end) && $stable(i_frame_end))
        else $error("output payload changed during stall");

    // The last pixel of a frame also closes its line.
    a_frame_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_end |-> i_line_end)
        else $error("frame end without line end");

    // A register write forces a geometry update before the next pixel.
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_ready |=> !i_pix_ready)
        else $error("pixel taken right after a register write");

    // Geometry is derived after reset before any pixel is taken.
    a_rst_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_pix_ready)
        else $error("pixel input ready right after reset");

endmodule

bind pixel_preprocess_pipeline_unit ppp_checker u_ppp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_ready (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_pixel_out (o_pix.pixel_out),
    .i_line_end  (o_pix.line_end),
    .i_frame_end (o_pix.frame_end),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready)
);
